/* hdl/gbts_pkg.sv */
// Shared types and constants for the gap-buffer text store.
// Used by gap_buffer_text_store_top, gbts_checker and the testbench; depends on nothing.
package gbts_pkg;

  localparam int unsigned PosW       = 13;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned FoundW     = 12;
  localparam int unsigned NeedleMax  = 8;
  localparam int unsigned NeedleW    = 64;
  localparam int unsigned NeedleLenW = 4;
  localparam int unsigned NeedleIdxW = 3;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_FIND   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  localparam logic CFG_NEEDLE_BYTES  = 1'b0;
  localparam logic CFG_NEEDLE_LENGTH = 1'b1;

  typedef struct packed {
    logic [1:0]       op;
    logic [PosW-1:0]  position;
    logic [PosW-1:0]  end_position;
    logic [ByteW-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ByteW-1:0]  read_byte;
    logic [FoundW-1:0] found_position;
    logic [PosW-1:0]   text_length;
  } out_item_t;

endpackage

/* hdl/gap_buffer_text_store_top.sv */
// Gap-buffer text store: byte RAM with a movable gap, sequenced by one FSM; uses gbts_pkg, gbts_ram.
// Read: a RAM read, then capture of the byte (skipped out of range); insert/delete: move the gap one
// byte at a time, then write or drop (an empty delete skips this); find: try each window, byte by byte.
// One item at a time: a new item is taken only in S_IDLE; a stalled result holds the FSM in S_DONE.
// Reset: empty text, gap spans the whole RAM, needle registers zero; RAM contents are not
// cleared, so no clearing pass is needed.
module gap_buffer_text_store_top #(
  parameter int unsigned CAPACITY = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gbts_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gbts_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [gbts_pkg::NeedleW-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = AW + 1;
  localparam int unsigned CW = (LW > gbts_pkg::PosW) ? LW : gbts_pkg::PosW;
  localparam logic [LW-1:0] CapL = LW'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE, S_MV, S_MV_WR, S_INS, S_DEL, S_RD, S_RD_CAP,
    S_FD_CHK, S_FD_RD, S_FD_CMP, S_DONE
  } state_e;

  state_e state_q;
  logic [LW-1:0] gf_q, gp_q, tgt_q, dn_q, fi_q;
  logic [gbts_pkg::NeedleIdxW-1:0] fj_q;
  gbts_pkg::in_item_t item_q;
  logic [gbts_pkg::NeedleW-1:0] needle_q;
  logic [gbts_pkg::NeedleLenW-1:0] nlen_q;
  logic [1:0] st_q;
  logic [gbts_pkg::ByteW-1:0] rb_q;
  logic [gbts_pkg::FoundW-1:0] fp_q;
  logic out_valid_q;
  gbts_pkg::out_item_t out_q;

  logic [LW-1:0] len, pos_c, end_c;
  logic [gbts_pkg::NeedleLenW-1:0] nsat;
  logic [LW:0] fwin_end, del_gp;
  logic [LW-1:0] ft;
  logic [AW-1:0] ft_addr, rd_addr_t;
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [gbts_pkg::ByteW-1:0] ram_wdata, ram_rdata;
  logic accept;

  assign len   = CapL - (gp_q - gf_q);
  assign pos_c = (CW'(in_data_i.position) > CW'(len)) ? len : LW'(in_data_i.position);
  assign end_c = (CW'(in_data_i.end_position) > CW'(len)) ? len
               : LW'(in_data_i.end_position);
  assign nsat  = (nlen_q > gbts_pkg::NeedleLenW'(gbts_pkg::NeedleMax))
               ? gbts_pkg::NeedleLenW'(gbts_pkg::NeedleMax) : nlen_q;
  assign fwin_end = {1'b0, fi_q} + (LW+1)'(nsat);
  assign del_gp   = {1'b0, gp_q} + {1'b0, dn_q};

  // Map text indexes of the search window and the read to RAM cells
  assign ft        = fi_q + LW'(fj_q);
  assign ft_addr   = (ft < gf_q) ? AW'(ft) : AW'(ft + (gp_q - gf_q));
  assign rd_addr_t = (LW'(item_q.position) < gf_q) ? AW'(item_q.position)
                   : AW'(LW'(item_q.position) + (gp_q - gf_q));

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Drive RAM ports from the current step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(gf_q);
    ram_wdata = ram_rdata;
    ram_raddr = AW'(gp_q);
    unique case (state_q)
      S_MV: begin
        ram_raddr = (tgt_q < gf_q) ? AW'(gf_q - LW'(1)) : AW'(gp_q);
      end
      S_MV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = (tgt_q < gf_q) ? AW'(gp_q - LW'(1)) : AW'(gf_q);
      end
      S_INS: begin
        ram_we    = (gf_q < gp_q);
        ram_wdata = item_q.data_byte;
      end
      S_RD:    ram_raddr = rd_addr_t;
      S_FD_RD: ram_raddr = ft_addr;
      default: ;
    endcase
  end

  gbts_ram #(
    .Width (gbts_pkg::ByteW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer: state, gap pointers, results and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gf_q        <= '0;
      gp_q        <= CapL;
      needle_q    <= '0;
      nlen_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      item_q      <= '0;
      tgt_q       <= '0;
      dn_q        <= '0;
      fi_q        <= '0;
      fj_q        <= '0;
      st_q        <= gbts_pkg::ST_OK;
      rb_q        <= '0;
      fp_q        <= '0;
    end else begin
      // hold config writes
      if (cfg_valid_i) begin
        if (cfg_index_i == gbts_pkg::CFG_NEEDLE_BYTES) begin
          needle_q <= cfg_data_i;
        end else begin
          nlen_q <= cfg_data_i[gbts_pkg::NeedleLenW-1:0];
        end
      end
      // drop a result once transferred, unless a new one is loaded now
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            item_q <= in_data_i;
            st_q   <= gbts_pkg::ST_OK;
            rb_q   <= '0;
            fp_q   <= '0;
            unique case (in_data_i.op)
              gbts_pkg::OP_INSERT: begin
                tgt_q   <= pos_c;
                state_q <= S_MV;
              end
              gbts_pkg::OP_DELETE: begin
                tgt_q <= pos_c;
                dn_q  <= end_c - pos_c;
                if (CW'(in_data_i.position) < CW'(end_c)) begin
                  state_q <= S_MV;
                end else begin
                  state_q <= S_DONE;
                end
              end
              gbts_pkg::OP_READ: begin
                if (CW'(in_data_i.position) >= CW'(len)) begin
                  state_q <= S_DONE;
                end else begin
                  state_q <= S_RD;
                end
              end
              default: begin
                fi_q    <= pos_c;
                fj_q    <= '0;
                state_q <= S_FD_CHK;
              end
            endcase
          end
        end
        S_MV: begin
          if (gf_q == tgt_q) begin
            state_q <= (item_q.op == gbts_pkg::OP_INSERT) ? S_INS : S_DEL;
          end else begin
            state_q <= S_MV_WR;
          end
        end
        S_MV_WR: begin
          // advance the gap one byte
          if (tgt_q < gf_q) begin
            gf_q <= gf_q - LW'(1);
            gp_q <= gp_q - LW'(1);
          end else begin
            gf_q <= gf_q + LW'(1);
            gp_q <= gp_q + LW'(1);
          end
          state_q <= S_MV;
        end
        S_INS: begin
          if (gf_q < gp_q) begin
            gf_q <= gf_q + LW'(1);
          end else begin
            st_q <= gbts_pkg::ST_FULL;
          end
          state_q <= S_DONE;
        end
        S_DEL: begin
          gp_q    <= (del_gp > (LW+1)'(CAPACITY)) ? CapL : LW'(del_gp);
          state_q <= S_DONE;
        end
        S_RD:     state_q <= S_RD_CAP;
        S_RD_CAP: begin
          rb_q    <= ram_rdata;
          state_q <= S_DONE;
        end
        S_FD_CHK: begin
          if (nsat == '0 || fwin_end > {1'b0, len}) begin
            st_q    <= gbts_pkg::ST_NOT_FOUND;
            state_q <= S_DONE;
          end else begin
            state_q <= S_FD_RD;
          end
        end
        S_FD_RD: state_q <= S_FD_CMP;
        S_FD_CMP: begin
          if (ram_rdata != needle_q[gbts_pkg::ByteW*fj_q +: gbts_pkg::ByteW]) begin
            fi_q    <= fi_q + LW'(1);
            fj_q    <= '0;
            state_q <= S_FD_CHK;
          end else if ({1'b0, fj_q} == nsat - gbts_pkg::NeedleLenW'(1)) begin
            fp_q    <= gbts_pkg::FoundW'(fi_q);
            state_q <= S_DONE;
          end else begin
            fj_q    <= fj_q + gbts_pkg::NeedleIdxW'(1);
            state_q <= S_FD_RD;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.status         <= st_q;
            out_q.read_byte      <= rb_q;
            out_q.found_position <= fp_q;
            out_q.text_length    <= gbts_pkg::PosW'(len);
            out_valid_q          <= 1'b1;
            state_q              <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/gbts_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// Stand-alone; no package dependency.
module gbts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* dv/gbts_checker.sv */
// Checker for the gap-buffer text store: watches input, result and register
// transfers, predicts each result from its own text model and compares.
// Depends on gbts_pkg.
module gbts_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  gbts_pkg::in_item_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  gbts_pkg::out_item_t out_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic                cfg_index_i,
  input  logic [63:0]         cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import gbts_pkg::*;

  localparam int Cap = 4096;

  // Plain text model: the gap layout is invisible from outside.
  logic [7:0]  text_bytes [$];
  logic [63:0] pattern;
  logic [3:0]  pattern_len;
  out_item_t   expected_results [$];

  assign pending_o = expected_results.size();

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  function automatic out_item_t apply_edit(input in_item_t it);
    out_item_t r;
    int len, p, e, n;
    bit hit;
    len = text_bytes.size();
    r = '0;
    r.status = ST_OK;
    p = it.position;
    case (it.op)
      OP_INSERT: begin
        if (p > len) p = len;
        if (len >= Cap) r.status = ST_FULL;
        else text_bytes.insert(p, it.data_byte);
      end
      OP_DELETE: begin
        e = it.end_position;
        if (e > len) e = len;
        for (int i = p; i < e; i++) text_bytes.delete(p);
      end
      OP_READ: begin
        if (p < len) r.read_byte = text_bytes[p];
      end
      default: begin
        n = (pattern_len > NeedleMax) ? NeedleMax : pattern_len;
        if (p > len) p = len;
        hit = 0;
        if (n > 0) begin
          for (int i = p; i + n <= len && !hit; i++) begin
            hit = 1;
            for (int k = 0; k < n; k++)
              if (text_bytes[i+k] != pattern[8*k +: 8]) hit = 0;
            if (hit) r.found_position = i[11:0];
          end
        end
        if (!hit) r.status = ST_NOT_FOUND;
      end
    endcase
    r.text_length = text_bytes.size();
    return r;
  endfunction

  // Track transfers on all three channels.
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t w;
    if (!rst_ni) begin
      fail_count_o = 0;
      pattern = '0;
      pattern_len = '0;
      text_bytes.delete();
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_NEEDLE_BYTES) pattern = cfg_data_i;
        else pattern_len = cfg_data_i[3:0];
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          w = expected_results.pop_front();
          if (out_data_i.status != w.status)
            report_mismatch("status", out_data_i.status, w.status);
          if (out_data_i.read_byte != w.read_byte)
            report_mismatch("read_byte", out_data_i.read_byte, w.read_byte);
          if (out_data_i.found_position != w.found_position)
            report_mismatch("found_position", out_data_i.found_position,
                            w.found_position);
          if (out_data_i.text_length != w.text_length)
            report_mismatch("text_length", out_data_i.text_length, w.text_length);
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(apply_edit(in_data_i));
    end
  end
endmodule

/* dv/tb_gap_buffer_text_store_top.sv */
// Stimulus and verdict for the gap-buffer text store.
// Depends on gbts_pkg, gap_buffer_text_store_top and gbts_checker.
module tb_gap_buffer_text_store_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gbts_pkg::*;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, in_stall_o, out_valid_o, out_stall_i = 0;
  logic cfg_valid_i = 0, cfg_ready_o, cfg_index_i = 0;
  logic [63:0] cfg_data_i = '0;
  in_item_t  in_data_i = '0;
  out_item_t out_data_o;
  int fail_count, pending;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_off = 0;
  int text_len_est = 0;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  gap_buffer_text_store_top uut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  gbts_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver stall pattern, with a long hold-off on request.
  always @(posedge clk_i) begin
    out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    #100ms;
    $display("gap_buffer_text_store_top verification failed");
    $finish;
  end

  task automatic send_item(input logic [1:0] op, input int p, input int e,
                           input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_data_i  <= '{op: op, position: p[12:0], end_position: e[12:0], data_byte: b};
    in_valid_i <= 1;
    do @(posedge clk_i); while (in_stall_o);
    in_valid_i <= 0;
    @(posedge clk_i);
    if (op == OP_INSERT && text_len_est < 4096) text_len_est++;
  endtask

  task automatic drain_and_wait();
    while (pending != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] v);
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    cfg_valid_i <= 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  // Random item biased toward the current text size and a small alphabet.
  task automatic random_item();
    int len, p, e, k;
    logic [1:0] op;
    len = text_len_est;
    k = $urandom_range(99);
    op = (k < 45) ? OP_INSERT : (k < 55) ? OP_DELETE : (k < 78) ? OP_READ : OP_FIND;
    p = ($urandom_range(15) == 0) ? $urandom_range(8191) : $urandom_range(len + 2);
    e = ($urandom_range(15) == 0) ? $urandom_range(8191) : p + $urandom_range(4);
    send_item(op, p, e, ($urandom_range(3) == 0) ? $urandom_range(255)
                                                  : 8'h61 + $urandom_range(2));
    if (op == OP_DELETE && p < e && p < len)
      text_len_est = len - (((e > len) ? len : e) - p);
  endtask

  initial begin
    int pcts[4][2] = '{'{0, 0}, '{62, 0}, '{0, 62}, '{18, 18}};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Directed: empty-text cases, then extremes of every field.
    send_item(OP_FIND, 0, 0, 0);
    send_item(OP_READ, 8191, 0, 0);
    send_item(OP_DELETE, 0, 8191, 0);
    send_item(OP_INSERT, 8191, 0, 8'hff);
    send_item(OP_INSERT, 0, 0, 8'h00);
    send_item(OP_INSERT, 1, 0, 8'h61);
    send_item(OP_INSERT, 3, 0, 8'h62);
    send_item(OP_READ, 0, 0, 0);
    send_item(OP_READ, 3, 0, 0);
    send_item(OP_READ, 4, 0, 0);
    drain_and_wait();
    write_reg(CFG_NEEDLE_BYTES, 64'h6261);
    write_reg(CFG_NEEDLE_LENGTH, 64'd2);
    send_item(OP_FIND, 0, 0, 0);
    send_item(OP_FIND, 8191, 0, 0);
    send_item(OP_DELETE, 3, 1, 0);
    send_item(OP_DELETE, 1, 2, 0);
    send_item(OP_FIND, 0, 0, 0);
    drain_and_wait();
    write_reg(CFG_NEEDLE_LENGTH, 64'd15);
    send_item(OP_FIND, 0, 0, 0);
    drain_and_wait();
    write_reg(CFG_NEEDLE_BYTES, '1);
    write_reg(CFG_NEEDLE_LENGTH, 64'd0);
    send_item(OP_FIND, 0, 0, 0);
    send_item(OP_DELETE, 0, 8191, 0);
    drain_and_wait();
    text_len_est = 0;
    // Far positions on a short text, then clear it.
    write_reg(CFG_NEEDLE_BYTES, 64'h61);
    write_reg(CFG_NEEDLE_LENGTH, 64'd1);
    send_item(OP_INSERT, 0, 0, 8'h61);
    send_item(OP_INSERT, 2048, 0, 8'h61);
    send_item(OP_READ, 4095, 0, 0);
    send_item(OP_FIND, 4000, 0, 0);
    send_item(OP_DELETE, 0, 8191, 0);
    drain_and_wait();
    text_len_est = 0;
    // Random phases under different needle settings and idling.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = pcts[ph][0];
      recv_stall_pct = pcts[ph][1];
      write_reg(CFG_NEEDLE_BYTES, {$urandom, $urandom} & 64'h0303030303030303
                                  | 64'h6060606060606060);
      write_reg(CFG_NEEDLE_LENGTH, (ph == 3) ? 64'd8 : 64'd1 + ph);
      if (ph == 1) begin
        // Hold off the receiver while the sender keeps offering.
        fork
          begin
            hold_off = 1;
            repeat (300) @(posedge clk_i);
            hold_off = 0;
          end
          repeat (20) random_item();
        join
      end
      for (int i = 0; i < 450; i++) random_item();
      drain_and_wait();
      // Bit-wide field coverage.
      send_item(OP_READ, $urandom_range(8191), $urandom_range(8191), 0);
      drain_and_wait();
    end
    if (fail_count == 0) begin
      $display("gap_buffer_text_store_top verification clean");
    end else begin
      $display("gap_buffer_text_store_top verification failed");
    end
    $finish;
  end
endmodule

/* sim.f */
hdl/gbts_pkg.sv
hdl/gbts_ram.sv
hdl/gap_buffer_text_store_top.sv
dv/gbts_checker.sv
dv/tb_gap_buffer_text_store_top.sv
